// ----- design/disc_obstacle_rasterizer_defines.svh -----
// assertion macros for the disc obstacle rasterizer
`ifndef DISC_OBSTACLE_RASTERIZER_DEFINES_SVH
`define DISC_OBSTACLE_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DOR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DOR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dor_pkg.sv -----
package dor_pkg;

  localparam int GRID_COLS = 512;
  localparam int GRID_ROWS = 256;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);

  // grid memory: one word holds WORD_BITS neighboring cells of a row
  localparam int WORD_BITS = 64;
  localparam int WSEL_W    = $clog2(WORD_BITS);
  localparam int WADDR_W   = ROW_W + COL_W - WSEL_W;
  localparam int MEM_DEPTH = 2 ** WADDR_W;

  localparam int CMD_W       = 2;
  localparam int CENTRE_W    = 12;
  localparam int CRD_W       = CENTRE_W + 1;
  localparam int CELL_SIZE_W = 11;
  localparam int RADIUS_W    = 6;
  localparam int SQ_W        = 2 * RADIUS_W;
  localparam int Y_W         = RADIUS_W + 1;
  localparam int COLIN_W     = 9;
  localparam int ROWIN_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STAMP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd1;

  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = 11'd10;
  localparam logic [RADIUS_W-1:0]    RADIUS_RST    = 6'd16;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_POINT,
    ST_RWAIT,
    ST_RESULT
  } state_t;

endpackage

// ----- design/dor_div.sv -----
// restoring divider, one quotient bit per cycle
module dor_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [dor_pkg::CENTRE_W-1:0]         dividend,
  input  logic [dor_pkg::CELL_SIZE_W-1:0]      divisor,
  output logic                                 done,
  output logic [dor_pkg::CENTRE_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(dor_pkg::CENTRE_W);

  logic                                busy;
  logic [CNT_W-1:0]                    cnt;
  logic [dor_pkg::CELL_SIZE_W-1:0]     rem;
  logic [dor_pkg::CENTRE_W-1:0]        quo;
  logic [dor_pkg::CELL_SIZE_W-1:0]     dvs;
  logic [dor_pkg::CELL_SIZE_W:0]       trial;
  logic [dor_pkg::CELL_SIZE_W:0]       diff;
  logic                                ge;

  assign trial    = {rem, quo[dor_pkg::CENTRE_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(dor_pkg::CENTRE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[dor_pkg::CELL_SIZE_W-1:0] : trial[dor_pkg::CELL_SIZE_W-1:0];
      quo <= {quo[dor_pkg::CENTRE_W-2:0], ge};
    end
  end

endmodule

// ----- design/disc_obstacle_rasterizer.sv -----
// Disc obstacle rasterizer: a 512 x 256 one-bit occupancy grid held in a 2048 x 64-bit
// synchronous memory, one item at a time. After reset the grid is swept to zero before the
// first item is taken (configuration writes work throughout). A clear lasts as long as the
// one-word-per-cycle sweep of all 2048 grid words. A read passes through memory read, bit
// pick and result. A stamp runs the serial divide of the centre by the cell size, then
// walks the disc column by column, stepping the integer square root down, and writes four
// read-modify-write cells per disc point through the single memory write port. A column
// or row that leaves the grid cuts the sweep short. A finished result sits in an output
// register, so the next item is taken while the result still waits on result_ready.
module disc_obstacle_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [dor_pkg::CMD_W-1:0]           cmd,
  input  logic [dor_pkg::CENTRE_W-1:0]        centre_x_mm,
  input  logic [dor_pkg::CENTRE_W-1:0]        centre_y_mm,
  input  logic [dor_pkg::COLIN_W-1:0]         cell_col,
  input  logic [dor_pkg::ROWIN_W-1:0]         cell_row,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                occupied,
  // configuration
  input  logic                                cfg_we,
  input  logic [dor_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dor_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "disc_obstacle_rasterizer_defines.svh"

  localparam int WADDR_W  = dor_pkg::WADDR_W;
  localparam int WSEL_W   = dor_pkg::WSEL_W;
  localparam int CRD_W    = dor_pkg::CRD_W;
  localparam int SQ_W     = dor_pkg::SQ_W;
  localparam int Y_W      = dor_pkg::Y_W;
  localparam int RADIUS_W = dor_pkg::RADIUS_W;
  localparam int CENTRE_W = dor_pkg::CENTRE_W;

  dor_pkg::state_t state, state_next;

  // configuration registers
  logic [dor_pkg::CELL_SIZE_W-1:0] cell_size_mm;
  logic [RADIUS_W-1:0]             radius_cells;

  logic accept;

  // clear sweep
  logic [WADDR_W-1:0] clr_addr;
  logic               clr_cmd;
  logic               clr_we;

  // stamp sequencing: x column, y row offset, k mirror quadrant
  logic [RADIUS_W-1:0] r;
  logic [SQ_W-1:0]     rr;
  logic [SQ_W-1:0]     t;      // r*r - x*x
  logic [RADIUS_W-1:0] s;      // running isqrt(t)
  logic [SQ_W-1:0]     ss;     // s*s
  logic [RADIUS_W-1:0] x;
  logic [Y_W-1:0]      y;
  logic [1:0]          k;

  logic                x_ok, y_ok, issue;
  logic [CRD_W-1:0]    cx_plus, cy_plus, cell_col_c, cell_row_c;
  logic [WADDR_W-1:0]  stamp_addr;
  logic [WSEL_W-1:0]   stamp_sel;

  // centre division
  logic                            div_start, div_done_x, div_done_y, div_done;
  logic [dor_pkg::CELL_SIZE_W-1:0] divisor;
  logic [CENTRE_W-1:0]             x0, y0;

  // read command
  logic [dor_pkg::COL_W-1:0] port_col;
  logic [dor_pkg::ROW_W-1:0] port_row;
  logic                      port_in_range;
  logic [WADDR_W-1:0]        port_addr;
  logic                      rd_ok;
  logic [WSEL_W-1:0]         rd_sel;
  logic                      res_bit;
  logic                      res_load;

  // read-modify-write pipeline and forwarding of the word written last cycle
  logic                          p_valid;
  logic [WADDR_W-1:0]            p_addr;
  logic [WSEL_W-1:0]             p_sel;
  logic                          last_valid;
  logic [WADDR_W-1:0]            last_addr;
  logic [dor_pkg::WORD_BITS-1:0] last_data;
  logic [dor_pkg::WORD_BITS-1:0] merge_base;

  // grid memory
  logic [dor_pkg::WORD_BITS-1:0] grid_mem [dor_pkg::MEM_DEPTH];
  logic                          mem_re, mem_we;
  logic [WADDR_W-1:0]            mem_raddr, mem_waddr;
  logic [dor_pkg::WORD_BITS-1:0] mem_rdata, mem_wdata;

  assign accept = item_valid & item_ready;

  // centre to cell, cell size zero divides as one
  assign divisor  = (cell_size_mm == '0) ? dor_pkg::CELL_SIZE_W'(1) : cell_size_mm;
  assign div_done = div_done_x & div_done_y;

  dor_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (centre_x_mm),
    .divisor  (divisor),
    .done     (div_done_x),
    .quotient (x0)
  );

  dor_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (centre_y_mm),
    .divisor  (divisor),
    .done     (div_done_y),
    .quotient (y0)
  );

  // strict inside test, both fail for good once x or y grows past the edge
  assign cx_plus = CRD_W'(x0) + CRD_W'(x);
  assign cy_plus = CRD_W'(y0) + CRD_W'(y);
  assign x_ok    = (cx_plus < CRD_W'(dor_pkg::GRID_COLS)) && (x0 > CENTRE_W'(x));
  assign y_ok    = (cy_plus < CRD_W'(dor_pkg::GRID_ROWS)) && (y0 > CENTRE_W'(y)) &&
                   (y <= Y_W'(s));

  // mirrored cell for quadrant k
  assign cell_col_c = k[1] ? (CRD_W'(x0) - CRD_W'(x)) : cx_plus;
  assign cell_row_c = k[0] ? (CRD_W'(y0) - CRD_W'(y)) : cy_plus;
  assign stamp_addr = {cell_row_c[dor_pkg::ROW_W-1:0], cell_col_c[dor_pkg::COL_W-1:WSEL_W]};
  assign stamp_sel  = cell_col_c[WSEL_W-1:0];

  assign port_col      = dor_pkg::COL_W'(cell_col);
  assign port_row      = dor_pkg::ROW_W'(cell_row);
  assign port_in_range = (CRD_W'(cell_col) < CRD_W'(dor_pkg::GRID_COLS)) &&
                         (CRD_W'(cell_row) < CRD_W'(dor_pkg::GRID_ROWS));
  assign port_addr     = {port_row, port_col[dor_pkg::COL_W-1:WSEL_W]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dor_pkg::ST_CLR: begin
        if (clr_addr == WADDR_W'(dor_pkg::MEM_DEPTH - 1)) begin
          state_next = clr_cmd ? dor_pkg::ST_RESULT : dor_pkg::ST_IDLE;
        end
      end
      dor_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            dor_pkg::CMD_CLEAR: state_next = dor_pkg::ST_CLR;
            dor_pkg::CMD_STAMP: state_next = dor_pkg::ST_DIV;
            dor_pkg::CMD_READ:  state_next = dor_pkg::ST_RWAIT;
            default:            state_next = dor_pkg::ST_RESULT;
          endcase
        end
      end
      dor_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (r == '0) ? dor_pkg::ST_RESULT : dor_pkg::ST_SQRT;
        end
      end
      dor_pkg::ST_SQRT: begin
        if (!x_ok) begin
          state_next = dor_pkg::ST_RESULT;
        end else if (ss <= t) begin
          state_next = dor_pkg::ST_POINT;
        end
      end
      dor_pkg::ST_POINT: begin
        if (!y_ok) begin
          state_next = (x == r - RADIUS_W'(1)) ? dor_pkg::ST_RESULT : dor_pkg::ST_SQRT;
        end
      end
      dor_pkg::ST_RWAIT: state_next = dor_pkg::ST_RESULT;
      dor_pkg::ST_RESULT: begin
        if (!result_valid || result_ready) begin
          state_next = dor_pkg::ST_IDLE;
        end
      end
      default: state_next = dor_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_ready = 1'b0;
    clr_we     = 1'b0;
    issue      = 1'b0;
    res_load   = 1'b0;
    div_start  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = stamp_addr;
    unique case (state)
      dor_pkg::ST_CLR: clr_we = 1'b1;
      dor_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        div_start  = item_valid && (cmd == dor_pkg::CMD_STAMP);
        mem_re     = item_valid && (cmd == dor_pkg::CMD_READ);
        mem_raddr  = port_addr;
      end
      dor_pkg::ST_POINT: begin
        issue  = y_ok;
        mem_re = y_ok;
      end
      dor_pkg::ST_RESULT: res_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  // write port: clear sweep or stamp write-back, never both
  assign merge_base = (last_valid && (last_addr == p_addr)) ? last_data : mem_rdata;
  assign mem_we     = clr_we | p_valid;
  assign mem_waddr  = clr_we ? clr_addr : p_addr;
  assign mem_wdata  = clr_we ? '0 : (merge_base | (dor_pkg::WORD_BITS'(1) << p_sel));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= grid_mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dor_pkg::ST_CLR;
      clr_addr     <= '0;
      clr_cmd      <= 1'b0;
      result_valid <= 1'b0;
      p_valid      <= 1'b0;
      last_valid   <= 1'b0;
      cell_size_mm <= dor_pkg::CELL_SIZE_RST;
      radius_cells <= dor_pkg::RADIUS_RST;
    end else begin
      state      <= state_next;
      p_valid    <= issue;
      last_valid <= mem_we;
      if (cfg_we) begin
        unique case (cfg_index)
          dor_pkg::REG_CELL_SIZE: cell_size_mm <= cfg_data;
          dor_pkg::REG_RADIUS:    radius_cells <= cfg_data[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        clr_cmd  <= (cmd == dor_pkg::CMD_CLEAR);
        clr_addr <= '0;
      end else if (clr_we) begin
        clr_addr <= clr_addr + WADDR_W'(1);
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_addr    <= stamp_addr;
    p_sel     <= stamp_sel;
    last_addr <= mem_waddr;
    last_data <= mem_wdata;
    if (res_load) begin
      occupied <= res_bit;
    end
    if (accept) begin
      r       <= radius_cells;
      rd_ok   <= port_in_range;
      rd_sel  <= port_col[WSEL_W-1:0];
      res_bit <= 1'b0;
    end
    case (state)
      dor_pkg::ST_DIV: begin
        rr <= SQ_W'(r) * SQ_W'(r);
        if (div_done) begin
          t  <= rr;
          ss <= rr;
          s  <= r;
          x  <= '0;
        end
      end
      dor_pkg::ST_SQRT: begin
        if (ss > t) begin
          // (s-1)^2 = s^2 - 2s + 1
          s  <= s - RADIUS_W'(1);
          ss <= ss - (SQ_W'(s) << 1) + SQ_W'(1);
        end else begin
          y <= '0;
          k <= '0;
        end
      end
      dor_pkg::ST_POINT: begin
        if (y_ok) begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            y <= y + Y_W'(1);
          end
        end else begin
          // (x+1)^2 = x^2 + 2x + 1
          x <= x + RADIUS_W'(1);
          t <= t - ((SQ_W'(x) << 1) + SQ_W'(1));
        end
      end
      dor_pkg::ST_RWAIT: res_bit <= rd_ok & mem_rdata[rd_sel];
      default: ;
    endcase
  end

  // stamp never writes row zero
  `DOR_ASSERT_IMPLIES(a_no_row_zero, p_valid, p_addr[WADDR_W-1 -: dor_pkg::ROW_W] != '0,
    "stamp wrote row zero")
  // the sweep and a stamp write-back never share the write port
  `DOR_ASSERT_IMPLIES(a_clr_excl, state == dor_pkg::ST_CLR, !p_valid,
    "stamp write during clear")
  // running square stays the square of the running root
  `DOR_ASSERT_IMPLIES(a_sq_track, state == dor_pkg::ST_SQRT, ss == (SQ_W'(s) * SQ_W'(s)),
    "sqrt square lost track")

endmodule
